>>> hdl/edge_signature_partition_enumerator_macros.svh
// assertion macros for the edge signature partition enumerator
// used by the modules that check their own control logic
`ifndef EDGE_SIGNATURE_PARTITION_ENUMERATOR_MACROS_SVH
`define EDGE_SIGNATURE_PARTITION_ENUMERATOR_MACROS_SVH

// checked on every clock edge out of reset
`define ESP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ESP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/esp_pkg.sv
// shared types and constants for the edge signature partition enumerator
// no dependencies
package esp_pkg;

  localparam int MAX_POS     = 5;
  localparam int POS_W       = 3;
  localparam int VAR_W       = 8;
  localparam int LBL_W       = 3;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  typedef logic [MAX_POS-1:0] cls_mask_t;

  typedef struct packed {
    logic clear;
    logic step;
  } canon_ctrl_t;

  typedef struct packed {
    logic clear;
    logic adv;
  } rgs_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CANON = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

endpackage

>>> hdl/esp_canon.sv
// first-occurrence relabelling unit: one variable matched against the class table per cycle
// depends on esp_pkg and the assertion macro header
`include "edge_signature_partition_enumerator_macros.svh"

module esp_canon import esp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  canon_ctrl_t       ctrl,
  input  logic [VAR_W-1:0]  var_in,
  output cls_mask_t         label_oh,
  output logic [POS_W-1:0]  cls_cnt
);

  logic [VAR_W-1:0] seen_r [MAX_POS];
  logic [POS_W-1:0] cnt_r, cnt_nxt;
  cls_mask_t        hit;
  cls_mask_t        new_oh;
  logic             found;

  always_comb begin
    for (int j = 0; j < MAX_POS; j++) begin
      hit[j]    = (POS_W'(j) < cnt_r) && (seen_r[j] == var_in);
      new_oh[j] = (POS_W'(j) == cnt_r);
    end
    found    = |hit;
    label_oh = found ? cls_mask_t'(hit & (~hit + 1'b1)) : new_oh;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.clear) begin
      cnt_nxt = '0;
    end else if (ctrl.step && !found) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // class table, written once per new class
  always_ff @(posedge clk) begin
    if (ctrl.step && !found && !ctrl.clear) begin
      seen_r[cnt_r] <= var_in;
    end
  end

  assign cls_cnt = cnt_r;

  `ESP_ASSERT(a_cnt_range, cnt_r <= POS_W'(MAX_POS), "class count past position count")
  `ESP_ASSERT(a_label_onehot, ctrl.step |-> $onehot(label_oh), "relabel result not one-hot")

endmodule

>>> hdl/esp_rgs.sv
// restricted growth string stepper: advances the block assignment by one partition per cycle
// in which ctrl.adv and has_next are high; depends on esp_pkg and the assertion macro header
`include "edge_signature_partition_enumerator_macros.svh"

module esp_rgs import esp_pkg::*; (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rgs_ctrl_t                       ctrl,
  input  logic [POS_W-1:0]                k,
  output logic [MAX_POS-1:0][LBL_W-1:0]   digits,
  output logic                            has_next
);

  logic [MAX_POS-1:0][LBL_W-1:0] growth_r, growth_nxt, stepped;
  logic [MAX_POS-1:0][LBL_W-1:0] pmax;
  logic [POS_W-1:0]              sel;
  logic                          found;

  always_comb begin
    pmax[0] = '0;
    for (int i = 1; i < MAX_POS; i++) begin
      pmax[i] = (growth_r[i-1] > pmax[i-1]) ? growth_r[i-1] : pmax[i-1];
    end
    // rightmost digit that may still grow
    found = 1'b0;
    sel   = '0;
    for (int i = 1; i < MAX_POS; i++) begin
      if ((POS_W'(i) < k) && (growth_r[i] <= pmax[i])) begin
        found = 1'b1;
        sel   = POS_W'(i);
      end
    end
    for (int i = 0; i < MAX_POS; i++) begin
      if (POS_W'(i) == sel) begin
        stepped[i] = growth_r[i] + 1'b1;
      end else if (POS_W'(i) > sel) begin
        stepped[i] = '0;
      end else begin
        stepped[i] = growth_r[i];
      end
    end
  end

  always_comb begin
    growth_nxt = growth_r;
    if (ctrl.clear) begin
      growth_nxt = '0;
    end else if (ctrl.adv && found) begin
      growth_nxt = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      growth_r <= '0;
    end else begin
      growth_r <= growth_nxt;
    end
  end

  assign digits   = growth_r;
  assign has_next = found;

  `ESP_ASSERT(a_first_block, growth_r[0] == '0, "first class left block zero")

endmodule

>>> hdl/edge_signature_partition_enumerator.sv
// edge signature partition enumerator top level: sequencer, input capture and output register
// depends on esp_pkg, esp_canon, esp_rgs and the assertion macro header
// an item of arity a with k distinct variables yields Bell(k) results
// the a variables go in turn through the single relabel match unit, then one result per cycle from the stepper
// the first result is registered at the output after the relabel pass; output stalls hold the stepper
// rst_n is synchronous and active low; it clears the sequencer, counts and output valid
`include "edge_signature_partition_enumerator_macros.svh"

module edge_signature_partition_enumerator import esp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // arity[2:0], var_0[10:3], var_1[18:11], var_2[26:19], var_3[34:27], var_4[42:35], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // sig_arity[2:0], label_0[5:3], label_1[8:6], label_2[11:9], label_3[14:12],
  // label_4[17:15], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  state_t                        state_r, state_nxt;
  logic [POS_W-1:0]              arity_r, pos_r, pos_nxt;
  logic [VAR_W-1:0]              vars_r [MAX_POS];
  cls_mask_t                     canon_r [MAX_POS];
  logic [OUT_TDATA_W-1:0]        out_tdata_r, out_data_nxt;
  logic                          out_tvalid_r, out_tvalid_nxt, out_tlast_r;

  logic [POS_W-1:0]              in_arity, arity_sat;
  logic                          accept, load;
  canon_ctrl_t                   canon_ctrl;
  rgs_ctrl_t                     rgs_ctrl;
  cls_mask_t                     label_oh;
  logic [POS_W-1:0]              cls_cnt;
  logic [MAX_POS-1:0][LBL_W-1:0] digits;
  logic                          has_next;
  logic [LBL_W-1:0]              lbl [MAX_POS];

  assign in_arity  = in_tdata[POS_W-1:0];
  assign arity_sat = (in_arity > POS_W'(MAX_POS)) ? POS_W'(MAX_POS) : in_arity;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign load      = (state_r == S_EMIT) && (!out_tvalid_r || out_tready);

  assign canon_ctrl.clear = accept;
  assign canon_ctrl.step  = (state_r == S_CANON);
  assign rgs_ctrl.clear   = accept;
  assign rgs_ctrl.adv     = load && has_next;

  esp_canon u_canon (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (canon_ctrl),
    .var_in   (vars_r[pos_r]),
    .label_oh (label_oh),
    .cls_cnt  (cls_cnt)
  );

  esp_rgs u_rgs (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (rgs_ctrl),
    .k        (cls_cnt),
    .digits   (digits),
    .has_next (has_next)
  );

  // block of each position through its class mask
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[POS_W-1:0] = arity_r;
    for (int i = 0; i < MAX_POS; i++) begin
      lbl[i] = '0;
      if (POS_W'(i) < arity_r) begin
        for (int c = 0; c < MAX_POS; c++) begin
          if (canon_r[i][c]) begin
            lbl[i] = lbl[i] | digits[c];
          end
        end
      end
      out_data_nxt[POS_W + i*LBL_W +: LBL_W] = lbl[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    case (state_r)
      S_IDLE: begin
        pos_nxt = '0;
        if (accept) begin
          state_nxt = (arity_sat == '0) ? S_EMIT : S_CANON;
        end
      end
      S_CANON: begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r == arity_r - 1'b1) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load && !has_next) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        pos_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_r        <= '0;
      arity_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (accept) begin
        arity_r <= arity_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_POS; i++) begin
        vars_r[i] <= in_tdata[POS_W + i*VAR_W +: VAR_W];
      end
    end
    if (state_r == S_CANON) begin
      canon_r[pos_r] <= label_oh;
    end
    if (load) begin
      out_tdata_r <= out_data_nxt;
      out_tlast_r <= !has_next;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `ESP_ASSERT(a_cnt_le_arity, (state_r == S_EMIT) |-> (cls_cnt <= arity_r), "more classes than positions")
  `ESP_ASSERT(a_direct_emit, ((state_r == S_EMIT) && $past(state_r == S_IDLE)) |-> (arity_r == '0), "relabel pass skipped")

endmodule
